// File: rtl/jddm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_pkg: shared types and constants of the drive mixer
// Field widths, register map, reset values and divider sizing.
// ----------------------------------------------------------------------------
package jddm_pkg;

	localparam int RAW_W  = 16;   // stick value, shaped axis, clamped mix
	localparam int FS_W   = 15;   // full_scale, dead_band
	localparam int SL_W   = 16;   // speed_limit
	localparam int TIME_W = 32;   // millisecond timestamps
	localparam int LVL_W  = 18;   // filtered speed level
	localparam int DRV_W  = 17;   // speed on the result word

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [FS_W-1:0]   FS_RESET      = 15'd1000;
	localparam logic [FS_W-1:0]   DB_RESET      = 15'd50;
	localparam logic [SL_W-1:0]   SL_RESET      = 16'd256;
	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd500;

	typedef enum logic [1:0] {
		REG_FULL_SCALE  = 2'd0,
		REG_DEAD_BAND   = 2'd1,
		REG_SPEED_LIMIT = 2'd2,
		REG_TIMEOUT     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [FS_W-1:0]   full_scale;
		logic [FS_W-1:0]   dead_band;
		logic [SL_W-1:0]   speed_limit;
		logic [TIME_W-1:0] timeout_limit_ms;
	} cfg_t;

	// shared divider: 32-bit dividend, 15-bit divisor, two quotient bits a cycle
	localparam int DIV_W      = 32;
	localparam int DEN_W      = 15;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: rtl/jddm_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_cmd_if: control tick channel
// One word per tick: command flag, stick values and timestamps.
// ----------------------------------------------------------------------------
interface jddm_cmd_if;
	logic                              valid;
	logic                              ready;
	logic                              has_command;
	logic signed [jddm_pkg::RAW_W-1:0] raw_throttle;
	logic signed [jddm_pkg::RAW_W-1:0] raw_turn;
	logic [jddm_pkg::TIME_W-1:0]       command_time_ms;
	logic [jddm_pkg::TIME_W-1:0]       now_ms;

	modport source (
		output valid, has_command, raw_throttle, raw_turn, command_time_ms, now_ms,
		input  ready
	);
	modport sink (
		input  valid, has_command, raw_throttle, raw_turn, command_time_ms, now_ms,
		output ready
	);
endinterface

// File: rtl/jddm_drive_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_drive_if: drive result channel
// One word per tick: wheel targets, link flag and shaped axes.
// ----------------------------------------------------------------------------
interface jddm_drive_if;
	logic                              valid;
	logic                              ready;
	logic signed [jddm_pkg::DRV_W-1:0] left_drive;
	logic signed [jddm_pkg::DRV_W-1:0] right_drive;
	logic                              link_up;
	logic signed [jddm_pkg::RAW_W-1:0] shaped_throttle;
	logic signed [jddm_pkg::RAW_W-1:0] shaped_turn;

	modport source (
		output valid, left_drive, right_drive, link_up, shaped_throttle, shaped_turn,
		input  ready
	);
	modport sink (
		input  valid, left_drive, right_drive, link_up, shaped_throttle, shaped_turn,
		output ready
	);
endinterface

// File: rtl/jddm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_div: shared unsigned divider
// Restoring division, two quotient bits per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module jddm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  jddm_pkg::div_req_t  req,
	output jddm_pkg::div_rsp_t  rsp
);

	logic [jddm_pkg::DIV_W-1:0]     work_q, work_c;
	logic [jddm_pkg::DEN_W-1:0]     rem_q, rem_c, den_q;
	logic [jddm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q, done_q;

	// quotient bits shift in at the bottom of the dividend register
	always_comb begin
		logic [jddm_pkg::DEN_W:0] trial;
		rem_c  = rem_q;
		work_c = work_q;
		trial  = '0;
		for (int i = 0; i < jddm_pkg::DIV_STEPS; i++) begin
			trial  = {rem_c, work_c[jddm_pkg::DIV_W-1]};
			work_c = {work_c[jddm_pkg::DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_c     = jddm_pkg::DEN_W'(trial - {1'b0, den_q});
				work_c[0] = 1'b1;
			end else begin
				rem_c = trial[jddm_pkg::DEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= jddm_pkg::DIV_CNT_W'(jddm_pkg::DIV_CYCLES - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.dividend;
			den_q  <= req.divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_c;
			rem_q  <= rem_c;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = work_q;

endmodule

// File: rtl/jddm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_regs: configuration registers
// APB-style write/read of full scale, dead band, speed limit and timeout.
// ----------------------------------------------------------------------------
module jddm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [jddm_pkg::APB_AW-1:0] paddr,
	input  logic [jddm_pkg::APB_DW-1:0] pwdata,
	output logic [jddm_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output jddm_pkg::cfg_t              cfg
);

	jddm_pkg::cfg_t     cfg_q;
	jddm_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = jddm_pkg::reg_idx_t'(paddr[jddm_pkg::APB_AW-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_scale       <= jddm_pkg::FS_RESET;
			cfg_q.dead_band        <= jddm_pkg::DB_RESET;
			cfg_q.speed_limit      <= jddm_pkg::SL_RESET;
			cfg_q.timeout_limit_ms <= jddm_pkg::TIMEOUT_RESET;
		end else if (wr_en) begin
			case (idx)
				jddm_pkg::REG_FULL_SCALE:  cfg_q.full_scale <= pwdata[jddm_pkg::FS_W-1:0];
				jddm_pkg::REG_DEAD_BAND:   cfg_q.dead_band  <= pwdata[jddm_pkg::FS_W-1:0];
				jddm_pkg::REG_SPEED_LIMIT: cfg_q.speed_limit <= pwdata[jddm_pkg::SL_W-1:0];
				jddm_pkg::REG_TIMEOUT:     cfg_q.timeout_limit_ms <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			jddm_pkg::REG_FULL_SCALE:  prdata = jddm_pkg::APB_DW'(cfg_q.full_scale);
			jddm_pkg::REG_DEAD_BAND:   prdata = jddm_pkg::APB_DW'(cfg_q.dead_band);
			jddm_pkg::REG_SPEED_LIMIT: prdata = jddm_pkg::APB_DW'(cfg_q.speed_limit);
			jddm_pkg::REG_TIMEOUT:     prdata = cfg_q.timeout_limit_ms;
			default:                   prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/jddm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_core: sequencer and datapath of the mixer
// Deadband, mixing, speed scaling and smoothing through one multiplier and
// the shared divider, then link timeout and the result register.
// ----------------------------------------------------------------------------
module jddm_core (
	input  logic            clk,
	input  logic            arst_n,
	input  jddm_pkg::cfg_t  cfg,
	jddm_cmd_if.sink        cmd,
	jddm_drive_if.source    drive
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_SHAPE    = 7'b0000010,
		ST_SPEED    = 7'b0000100,
		ST_DIV_GO   = 7'b0001000,
		ST_DIV_WAIT = 7'b0010000,
		ST_MIX      = 7'b0100000,
		ST_FINISH   = 7'b1000000
	} state_t;

	localparam int RW = jddm_pkg::RAW_W;
	localparam int FW = jddm_pkg::FS_W;
	localparam int LW = jddm_pkg::LVL_W;
	localparam int DW = jddm_pkg::DIV_W;

	state_t state_q;
	logic   idx_q, speed_ph_q;

	logic                          has_cmd_q, neg_q;
	logic [RW-1:0]                 raw_q [2];
	logic [jddm_pkg::TIME_W-1:0]   cmd_time_q, now_q, last_cmd_q;
	logic [RW-1:0]                 shp_q [2];
	logic [RW-1:0]                 mix_q [2];
	logic [LW-1:0]                 lvl_q [2];
	logic [RW-1:0]                 held_q [2];
	logic                          link_q;
	logic [DW-1:0]                 prod_q;
	logic [jddm_pkg::DEN_W-1:0]    den_q;

	logic                          out_valid_q, out_link_q;
	logic [jddm_pkg::DRV_W-1:0]    out_left_q, out_right_q;
	logic [RW-1:0]                 out_thr_q, out_turn_q;

	jddm_pkg::div_req_t div_req;
	jddm_pkg::div_rsp_t div_rsp;

	jddm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------- deadband operand ----------------
	logic [RW-1:0] raw_sel, raw_mag, fs_ext, db_ext;
	logic          in_band, band_wide;

	assign raw_sel   = raw_q[idx_q];
	assign raw_mag   = raw_sel[RW-1] ? (~raw_sel + RW'(1)) : raw_sel;
	assign fs_ext    = {1'b0, cfg.full_scale};
	assign db_ext    = {1'b0, cfg.dead_band};
	assign in_band   = raw_mag <= db_ext;
	assign band_wide = cfg.full_scale <= cfg.dead_band;

	// ---------------- speed operand ----------------
	logic [RW-1:0] mix_sel, mix_abs;
	logic [FW-1:0] mix_mag;

	assign mix_sel = mix_q[idx_q];
	assign mix_abs = mix_sel[RW-1] ? (~mix_sel + RW'(1)) : mix_sel;
	assign mix_mag = mix_abs[FW-1:0];   // clamped to full_scale

	// ---------------- shared multiplier ----------------
	logic [RW-1:0]              mul_a;
	logic [jddm_pkg::SL_W-1:0]  mul_b;
	logic [DW-1:0]              mul_p;

	always_comb begin
		if (state_q == ST_SPEED) begin
			mul_a = {1'b0, mix_mag};
			mul_b = cfg.speed_limit;
		end else begin
			mul_a = raw_mag - db_ext;
			mul_b = fs_ext;
		end
	end
	assign mul_p = DW'(mul_a) * DW'(mul_b);

	assign div_req.start    = (state_q == ST_DIV_GO);
	assign div_req.dividend = prod_q;
	assign div_req.divisor  = den_q;

	// ---------------- divider result ----------------
	logic [FW-1:0] q_clamp;
	logic [RW-1:0] q_ext, shp_div;
	logic [LW-1:0] spd_ext, spd_new;

	assign q_clamp = (div_rsp.quotient > DW'(cfg.full_scale)) ? cfg.full_scale
	               : div_rsp.quotient[FW-1:0];
	assign q_ext   = {1'b0, q_clamp};
	assign shp_div = neg_q ? (~q_ext + RW'(1)) : q_ext;
	assign spd_ext = LW'(div_rsp.quotient[jddm_pkg::SL_W-1:0]);
	assign spd_new = neg_q ? (~spd_ext + LW'(1)) : spd_ext;

	// smoothing: jump on sign reversal, else floor((old + 3*new) / 4)
	logic [LW-1:0] lvl_old, lvl_smooth;
	logic [LW+1:0] smooth_sum;
	logic          old_pos, old_neg, new_pos, new_neg;

	assign lvl_old    = lvl_q[idx_q];
	assign old_neg    = lvl_old[LW-1];
	assign old_pos    = !lvl_old[LW-1] && (lvl_old != '0);
	assign new_neg    = spd_new[LW-1];
	assign new_pos    = !spd_new[LW-1] && (spd_new != '0);
	assign smooth_sum = {{2{lvl_old[LW-1]}}, lvl_old} + {{2{spd_new[LW-1]}}, spd_new}
	                  + {spd_new[LW-1], spd_new, 1'b0};
	assign lvl_smooth = ((old_pos && new_neg) || (old_neg && new_pos)) ? spd_new
	                  : smooth_sum[LW+1:2];

	// ---------------- mixing ----------------
	function automatic logic [RW-1:0] clamp_mix(input logic [RW:0] v,
	                                            input logic [FW-1:0] fs);
		logic signed [RW:0] sv, hi, lo;
		sv = v;
		hi = {2'b00, fs};
		lo = -hi;
		if (sv > hi)
			return hi[RW-1:0];
		else if (sv < lo)
			return lo[RW-1:0];
		else
			return v[RW-1:0];
	endfunction

	logic [RW:0]   mix_sum, mix_dif;
	logic [RW-1:0] mix_l, mix_r;
	logic          sticks_zero;

	assign mix_sum     = {shp_q[0][RW-1], shp_q[0]} + {shp_q[1][RW-1], shp_q[1]};
	assign mix_dif     = {shp_q[0][RW-1], shp_q[0]} - {shp_q[1][RW-1], shp_q[1]};
	assign mix_l       = clamp_mix(mix_sum, cfg.full_scale);
	assign mix_r       = clamp_mix(mix_dif, cfg.full_scale);
	assign sticks_zero = (shp_q[0] == '0) && (shp_q[1] == '0);

	// ---------------- link timeout ----------------
	logic [jddm_pkg::TIME_W-1:0] last_eff, age;
	logic                        drop, out_free;

	assign last_eff = has_cmd_q ? cmd_time_q : last_cmd_q;
	assign age      = now_q - last_eff;
	assign drop     = (last_eff == '0) || (age > cfg.timeout_limit_ms);
	assign out_free = !out_valid_q || drive.ready;

	// ---------------- sequencer and state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= 1'b0;
			speed_ph_q  <= 1'b0;
			out_valid_q <= 1'b0;
			lvl_q[0]    <= '0;
			lvl_q[1]    <= '0;
			held_q[0]   <= '0;
			held_q[1]   <= '0;
			last_cmd_q  <= '0;
			link_q      <= 1'b0;
		end else begin
			// in ST_FINISH an accepted word is replaced by the next one below
			if (drive.valid && drive.ready && state_q != ST_FINISH)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						idx_q      <= 1'b0;
						speed_ph_q <= 1'b0;
						state_q    <= cmd.has_command ? ST_SHAPE : ST_FINISH;
					end
				end
				ST_SHAPE: begin
					if (in_band || band_wide) begin
						idx_q <= 1'b1;
						if (idx_q)
							state_q <= ST_MIX;
					end else begin
						state_q <= ST_DIV_GO;
					end
				end
				ST_SPEED: begin
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						if (speed_ph_q)
							lvl_q[idx_q] <= lvl_smooth;
						idx_q <= 1'b1;
						if (!idx_q)
							state_q <= speed_ph_q ? ST_SPEED : ST_SHAPE;
						else
							state_q <= speed_ph_q ? ST_FINISH : ST_MIX;
					end
				end
				ST_MIX: begin
					idx_q      <= 1'b0;
					speed_ph_q <= 1'b1;
					if (sticks_zero) begin
						lvl_q[0] <= '0;
						lvl_q[1] <= '0;
						state_q  <= ST_FINISH;
					end else begin
						state_q <= ST_SPEED;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (has_cmd_q)
							last_cmd_q <= cmd_time_q;
						if (drop) begin
							held_q[0] <= '0;
							held_q[1] <= '0;
							lvl_q[0]  <= '0;
							lvl_q[1]  <= '0;
							link_q    <= 1'b0;
						end else if (has_cmd_q) begin
							held_q[0] <= shp_q[0];
							held_q[1] <= shp_q[1];
							link_q    <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.valid) begin
			has_cmd_q  <= cmd.has_command;
			raw_q[0]   <= cmd.raw_throttle;
			raw_q[1]   <= cmd.raw_turn;
			cmd_time_q <= cmd.command_time_ms;
			now_q      <= cmd.now_ms;
		end
		if (state_q == ST_SHAPE) begin
			prod_q <= mul_p;
			den_q  <= cfg.full_scale - cfg.dead_band;
			neg_q  <= raw_sel[RW-1];
			if (in_band)
				shp_q[idx_q] <= '0;
			else if (band_wide)
				shp_q[idx_q] <= raw_sel[RW-1] ? (~fs_ext + RW'(1)) : fs_ext;
		end
		if (state_q == ST_SPEED) begin
			prod_q <= mul_p;
			den_q  <= cfg.full_scale;
			neg_q  <= mix_sel[RW-1];
		end
		if (state_q == ST_DIV_WAIT && div_rsp.done && !speed_ph_q)
			shp_q[idx_q] <= shp_div;
		if (state_q == ST_MIX) begin
			mix_q[0] <= mix_l;
			mix_q[1] <= mix_r;
		end
		if (state_q == ST_FINISH && out_free) begin
			out_link_q  <= drop ? 1'b0 : (has_cmd_q | link_q);
			out_left_q  <= drop ? '0 : lvl_q[0][jddm_pkg::DRV_W-1:0];
			out_right_q <= drop ? '0 : lvl_q[1][jddm_pkg::DRV_W-1:0];
			out_thr_q   <= drop ? '0 : (has_cmd_q ? shp_q[0] : held_q[0]);
			out_turn_q  <= drop ? '0 : (has_cmd_q ? shp_q[1] : held_q[1]);
		end
	end

	assign cmd.ready             = (state_q == ST_IDLE);
	assign drive.valid           = out_valid_q;
	assign drive.left_drive      = out_left_q;
	assign drive.right_drive     = out_right_q;
	assign drive.link_up         = out_link_q;
	assign drive.shaped_throttle = out_thr_q;
	assign drive.shaped_turn     = out_turn_q;

endmodule

// File: rtl/joystick_differential_drive_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer_unit: arcade drive mixer, top level
// Tick with a command: when both axes leave the band the result word takes four
//   passes through the shared divider, two to shape the axes, two to scale speed.
//   An axis inside the band skips its shaping pass; zero shaped axes skip the speed passes.
// Tick without a command: straight from accept to the result register. One tick
//   in work at a time; next accept in the cycle after the result loads,
//   later while the previous word still waits in the output register.
// Reset (arst_n low, async): registers to defaults, levels/link/held cleared.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [jddm_pkg::APB_AW-1:0] paddr,
	input  logic [jddm_pkg::APB_DW-1:0] pwdata,
	output logic [jddm_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	jddm_cmd_if.sink                    cmd,
	jddm_drive_if.source                drive
);

	jddm_pkg::cfg_t cfg;

	jddm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	jddm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.drive  (drive)
	);

`ifndef SYNTHESIS
	// one tick at a time: no new word taken right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("tick accepted while busy");

	// a dropped link shows all-zero targets and axes
	a_link_down_zero: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid && !drive.link_up |-> drive.left_drive == '0 &&
		drive.right_drive == '0 && drive.shaped_throttle == '0 &&
		drive.shaped_turn == '0)
		else $error("nonzero output with link down");

	// filtered targets never reach the most negative code
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid |-> drive.left_drive != {1'b1, {(jddm_pkg::DRV_W-1){1'b0}}} &&
		drive.right_drive != {1'b1, {(jddm_pkg::DRV_W-1){1'b0}}})
		else $error("drive target out of range");
`endif

endmodule
